/* rtl/core/bsc_pkg.sv */
package bsc_pkg;

	// raw conversion code that marks a sensor that is not ready
	localparam logic [19:0] AdcNotReady = 20'h80000;

	// result status codes
	localparam logic [1:0] StatusOk       = 2'd0;
	localparam logic [1:0] StatusNotReady = 2'd1;
	localparam logic [1:0] StatusInvalid  = 2'd2;

	// configuration register indexes
	localparam logic [1:0] RegTempCal   = 2'd0;
	localparam logic [1:0] RegPressCalA = 2'd1;
	localparam logic [1:0] RegPressCalB = 2'd2;
	localparam logic [1:0] RegPressCalC = 2'd3;

	// divider: quotient bits, bits per stage, stage count
	localparam int QuotBits       = 64;
	localparam int DivBitsPerStep = 2;
	localparam int DivSteps       = QuotBits / DivBitsPerStep;

	typedef struct packed {
		logic [19:0] adc_pressure;
		logic [19:0] adc_temperature;
	} sample_t;

	typedef struct packed {
		logic signed [31:0] temperature_centi;
		logic [31:0]        pressure_q24_8;
		logic [1:0]         status;
	} result_t;

	// calibration words split into coefficients
	typedef struct packed {
		logic [15:0]        t1;
		logic signed [15:0] t2;
		logic signed [15:0] t3;
		logic [15:0]        p1;
		logic signed [15:0] p2;
		logic signed [15:0] p3;
		logic signed [15:0] p4;
		logic signed [15:0] p5;
		logic signed [15:0] p6;
		logic signed [15:0] p7;
		logic signed [15:0] p8;
		logic signed [15:0] p9;
	} cal_t;

	// per-item side information that travels with the data
	typedef struct packed {
		logic               not_ready;
		logic               div_zero;
		logic signed [31:0] temp;
	} tag_t;

endpackage

/* rtl/core/bsc_stream_if.sv */
interface bsc_stream_if #(parameter type payload_t = logic);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

/* rtl/core/bsc_temp.sv */
// Temperature compensation, six stages; also forms v1 = fine - 128000
module bsc_temp (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                adv,
	input  logic                in_valid,
	input  bsc_pkg::sample_t    in_data,
	input  bsc_pkg::cal_t       cal,
	output logic                out_valid,
	output bsc_pkg::tag_t       out_tag,
	output logic signed [32:0]  out_v1,
	output logic [19:0]         out_adc_p
);

	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6;
	logic nr_s1, nr_s2, nr_s3, nr_s4, nr_s5, nr_s6;
	logic [19:0] adc_p_s1, adc_p_s2, adc_p_s3, adc_p_s4, adc_p_s5, adc_p_s6;

	logic signed [17:0] a0;
	logic signed [16:0] d;
	logic signed [17:0] a0_s1;
	logic signed [16:0] d_s1;
	logic signed [33:0] ma;
	logic signed [33:0] md;
	logic signed [31:0] ma_s2, md_s2;
	logic signed [31:0] a_s3, b0_s3;
	logic signed [47:0] mb;
	logic signed [31:0] a_s4, mb_s4;
	logic signed [31:0] fine_s5;
	logic signed [31:0] f5;
	logic signed [31:0] temp_s6;
	logic signed [32:0] v1_s6;

	// stage 1: offsets from T1
	assign a0 = $signed({1'b0, in_data.adc_temperature[19:3]}) - $signed({1'b0, cal.t1, 1'b0});
	assign d  = $signed({1'b0, in_data.adc_temperature[19:4]}) - $signed({1'b0, cal.t1});

	// stage 2 products
	assign ma = a0_s1 * cal.t2;
	assign md = d_s1 * d_s1;

	// stage 4 product
	assign mb = b0_s3 * cal.t3;

	// stage 6: round fine temperature to centi-degrees
	assign f5 = (fine_s5 <<< 2) + fine_s5 + 32'sd128;

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
		end
	end

	// data path
	always_ff @(posedge clk) begin
		if (adv) begin
			nr_s1    <= (in_data.adc_pressure == bsc_pkg::AdcNotReady) ||
				(in_data.adc_temperature == bsc_pkg::AdcNotReady);
			adc_p_s1 <= in_data.adc_pressure;
			a0_s1    <= a0;
			d_s1     <= d;

			nr_s2    <= nr_s1;
			adc_p_s2 <= adc_p_s1;
			ma_s2    <= ma[31:0];
			md_s2    <= md[31:0];

			nr_s3    <= nr_s2;
			adc_p_s3 <= adc_p_s2;
			a_s3     <= ma_s2 >>> 11;
			b0_s3    <= md_s2 >>> 12;

			nr_s4    <= nr_s3;
			adc_p_s4 <= adc_p_s3;
			a_s4     <= a_s3;
			mb_s4    <= mb[31:0];

			nr_s5    <= nr_s4;
			adc_p_s5 <= adc_p_s4;
			fine_s5  <= a_s4 + (mb_s4 >>> 14);

			nr_s6    <= nr_s5;
			adc_p_s6 <= adc_p_s5;
			temp_s6  <= f5 >>> 8;
			v1_s6    <= $signed({fine_s5[31], fine_s5}) - 33'sd128000;
		end
	end

	assign out_valid         = valid_s6;
	assign out_tag.not_ready = nr_s6;
	assign out_tag.div_zero  = 1'b0;
	assign out_tag.temp      = temp_s6;
	assign out_v1            = v1_s6;
	assign out_adc_p         = adc_p_s6;

endmodule

/* rtl/core/bsc_poly.sv */
// Pressure polynomial, six stages; ends with sign/magnitude divider operands
module bsc_poly (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               adv,
	input  logic               in_valid,
	input  bsc_pkg::tag_t      in_tag,
	input  logic signed [32:0] in_v1,
	input  logic [19:0]        in_adc_p,
	input  bsc_pkg::cal_t      cal,
	output logic               out_valid,
	output bsc_pkg::tag_t      out_tag,
	output logic [63:0]        out_num,
	output logic [30:0]        out_den,
	output logic               out_qneg
);

	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6;
	bsc_pkg::tag_t tag_s1, tag_s2, tag_s3, tag_s4, tag_s5, tag_s6;
	logic [19:0] adc_p_s1, adc_p_s2, adc_p_s3;

	logic signed [65:0] vv;
	logic signed [48:0] m5, m2;
	logic signed [63:0] vv_s1;
	logic signed [48:0] m5_s1, m2_s1, m5_s2, m2_s2;
	logic signed [79:0] v2a, m3;
	logic signed [63:0] v2a_s2, m3_s2;
	logic signed [63:0] m5x, m2x, p4x;
	logic signed [63:0] v2_s3, v1b_s3;
	logic [20:0]        pn;
	logic signed [63:0] x_s4, num0_s4;
	logic signed [80:0] mx;
	logic signed [76:0] mn;
	logic signed [63:0] mx_s5, mn_s5;
	logic               dneg, nneg;
	logic [63:0]        num_s6;
	logic [30:0]        den_s6;
	logic               qneg_s6;

	// stage 1 products of v1
	assign vv = in_v1 * in_v1;
	assign m5 = in_v1 * cal.p5;
	assign m2 = in_v1 * cal.p2;

	// stage 2 products of v1 squared
	assign v2a = vv_s1 * cal.p6;
	assign m3  = vv_s1 * cal.p3;

	// stage 3 sign extensions
	assign m5x = 64'(m5_s2);
	assign m2x = 64'(m2_s2);
	assign p4x = 64'(cal.p4);

	// stage 4 numerator base
	assign pn = 21'h100000 - {1'b0, adc_p_s3};

	// stage 5 products
	assign mx = x_s4 * $signed({1'b0, cal.p1});
	assign mn = num0_s4 * 13'sd3125;

	// stage 6 signs
	assign dneg = mx_s5[63];
	assign nneg = mn_s5[63];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tag_s1   <= in_tag;
			adc_p_s1 <= in_adc_p;
			vv_s1    <= vv[63:0];
			m5_s1    <= m5;
			m2_s1    <= m2;

			tag_s2   <= tag_s1;
			adc_p_s2 <= adc_p_s1;
			v2a_s2   <= v2a[63:0];
			m3_s2    <= m3[63:0];
			m5_s2    <= m5_s1;
			m2_s2    <= m2_s1;

			tag_s3   <= tag_s2;
			adc_p_s3 <= adc_p_s2;
			v2_s3    <= v2a_s2 + (m5x <<< 17) + (p4x <<< 35);
			v1b_s3   <= (m3_s2 >>> 8) + (m2x <<< 12);

			tag_s4   <= tag_s3;
			x_s4     <= v1b_s3 + 64'sh0000_8000_0000_0000;
			num0_s4  <= $signed({12'd0, pn, 31'd0}) - v2_s3;

			tag_s5   <= tag_s4;
			mx_s5    <= mx[63:0];
			mn_s5    <= mn[63:0];

			// divisor is mx >>> 33, which fits 31 bits signed
			tag_s6.not_ready <= tag_s5.not_ready;
			tag_s6.div_zero  <= (mx_s5[63:33] == 31'd0);
			tag_s6.temp      <= tag_s5.temp;
			den_s6  <= dneg ? (31'd0 - mx_s5[63:33]) : mx_s5[63:33];
			num_s6  <= nneg ? (64'd0 - mn_s5) : mn_s5;
			qneg_s6 <= nneg ^ dneg;
		end
	end

	assign out_valid = valid_s6;
	assign out_tag   = tag_s6;
	assign out_num   = num_s6;
	assign out_den   = den_s6;
	assign out_qneg  = qneg_s6;

endmodule

/* rtl/core/bsc_div.sv */
// Pipelined restoring divider: magnitudes, two quotient bits per stage.
// Numerator bits shift out of nq at the top while quotient bits fill in below.
module bsc_div (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          adv,
	input  logic          in_valid,
	input  bsc_pkg::tag_t in_tag,
	input  logic [63:0]   in_num,
	input  logic [30:0]   in_den,
	input  logic          in_qneg,
	output logic          out_valid,
	output bsc_pkg::tag_t out_tag,
	output logic [63:0]   out_quot,
	output logic          out_qneg
);

	logic          valid_s [bsc_pkg::DivSteps];
	logic [63:0]   nq_s    [bsc_pkg::DivSteps];
	logic [30:0]   rem_s   [bsc_pkg::DivSteps];
	logic [30:0]   den_s   [bsc_pkg::DivSteps];
	logic          qneg_s  [bsc_pkg::DivSteps];
	bsc_pkg::tag_t tag_s   [bsc_pkg::DivSteps];

	for (genvar k = 0; k < bsc_pkg::DivSteps; k++) begin : g_step
		logic          v_in;
		logic [63:0]   n_in;
		logic [30:0]   r_in;
		logic [30:0]   d_in;
		logic          q_in;
		bsc_pkg::tag_t t_in;
		logic [31:0]   r1, r2;
		logic          ge1, ge2;
		logic [30:0]   r1n, r2n;
		logic [63:0]   n1, n2;

		if (k == 0) begin : g_first
			assign v_in = in_valid;
			assign n_in = in_num;
			assign r_in = '0;
			assign d_in = in_den;
			assign q_in = in_qneg;
			assign t_in = in_tag;
		end else begin : g_next
			assign v_in = valid_s[k-1];
			assign n_in = nq_s[k-1];
			assign r_in = rem_s[k-1];
			assign d_in = den_s[k-1];
			assign q_in = qneg_s[k-1];
			assign t_in = tag_s[k-1];
		end

		// first bit
		assign r1  = {r_in, n_in[63]};
		assign ge1 = (r1 >= {1'b0, d_in});
		assign r1n = ge1 ? 31'(r1 - {1'b0, d_in}) : r1[30:0];
		assign n1  = {n_in[62:0], ge1};

		// second bit
		assign r2  = {r1n, n1[63]};
		assign ge2 = (r2 >= {1'b0, d_in});
		assign r2n = ge2 ? 31'(r2 - {1'b0, d_in}) : r2[30:0];
		assign n2  = {n1[62:0], ge2};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k] <= 1'b0;
			end else if (adv) begin
				valid_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				nq_s[k]   <= n2;
				rem_s[k]  <= r2n;
				den_s[k]  <= d_in;
				qneg_s[k] <= q_in;
				tag_s[k]  <= t_in;
			end
		end
	end

	assign out_valid = valid_s[bsc_pkg::DivSteps-1];
	assign out_tag   = tag_s[bsc_pkg::DivSteps-1];
	assign out_quot  = nq_s[bsc_pkg::DivSteps-1];
	assign out_qneg  = qneg_s[bsc_pkg::DivSteps-1];

endmodule

/* rtl/core/bsc_post.sv */
// Post-division correction terms, six stages; the last stage is the output register
module bsc_post (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             adv,
	input  logic             in_valid,
	input  bsc_pkg::tag_t    in_tag,
	input  logic [63:0]      in_quot,
	input  logic             in_qneg,
	input  bsc_pkg::cal_t    cal,
	output logic             out_valid,
	output bsc_pkg::result_t out_data
);

	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6;
	bsc_pkg::tag_t tag_s1, tag_s2, tag_s3, tag_s4, tag_s5;

	logic signed [63:0] p_s1, p_s2, p_s3, p_s4;
	logic signed [63:0] p13;
	logic signed [79:0] m9, m8;
	logic signed [63:0] m9_s2, p13_s2, m8_s2, m8_s3, m8_s4;
	logic [63:0]        lo;
	logic [31:0]        c1, c2;
	logic [63:0]        lo_s3;
	logic [31:0]        c1_s3, c2_s3;
	logic signed [63:0] m99_s4;
	logic signed [63:0] s_s5;
	logic [31:0]        p7x, pres;
	bsc_pkg::result_t   res_s6;

	// stage 2 products
	assign p13 = p_s1 >>> 13;
	assign m9  = p13 * cal.p9;
	assign m8  = p_s1 * cal.p8;

	// stage 3: low 64 bits of m9 * p13 from 32-bit partial products
	assign lo = {32'd0, m9_s2[31:0]} * {32'd0, p13_s2[31:0]};
	assign c1 = m9_s2[63:32] * p13_s2[31:0];
	assign c2 = m9_s2[31:0] * p13_s2[63:32];

	// stage 6: final offset, low 32 bits
	assign p7x  = {{12{cal.p7[15]}}, cal.p7, 4'd0};
	assign pres = s_s5[39:8] + p7x;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tag_s1 <= in_tag;
			p_s1   <= in_qneg ? $signed(64'd0 - in_quot) : $signed(in_quot);

			tag_s2 <= tag_s1;
			p_s2   <= p_s1;
			p13_s2 <= p13;
			m9_s2  <= m9[63:0];
			m8_s2  <= m8[63:0];

			tag_s3 <= tag_s2;
			p_s3   <= p_s2;
			m8_s3  <= m8_s2;
			lo_s3  <= lo;
			c1_s3  <= c1;
			c2_s3  <= c2;

			tag_s4 <= tag_s3;
			p_s4   <= p_s3;
			m8_s4  <= m8_s3;
			m99_s4 <= $signed(lo_s3 + {c1_s3 + c2_s3, 32'd0});

			tag_s5 <= tag_s4;
			s_s5   <= p_s4 + (m99_s4 >>> 25) + (m8_s4 >>> 19);

			// status and field masking
			if (tag_s5.not_ready) begin
				res_s6.temperature_centi <= '0;
				res_s6.pressure_q24_8    <= '0;
				res_s6.status            <= bsc_pkg::StatusNotReady;
			end else if (tag_s5.div_zero) begin
				res_s6.temperature_centi <= tag_s5.temp;
				res_s6.pressure_q24_8    <= '0;
				res_s6.status            <= bsc_pkg::StatusInvalid;
			end else begin
				res_s6.temperature_centi <= tag_s5.temp;
				res_s6.pressure_q24_8    <= pres;
				res_s6.status            <= (pres == 32'd0) ? bsc_pkg::StatusInvalid :
					bsc_pkg::StatusOk;
			end
		end
	end

	assign out_valid = valid_s6;
	assign out_data  = res_s6;

endmodule

/* rtl/core/baro_sensor_compensation_core.sv */
// Barometric sensor compensation core.
// Input channel "sample" carries one raw 20-bit pressure and one raw 20-bit
// temperature conversion per transaction; output channel "result" returns the
// temperature in 0.01 degC, the pressure in unsigned Q24.8 Pa and a status.
// The user must load calibration words through the write port (cfg_we, cfg_index,
// cfg_wdata) while no transaction is in flight; the core does not enforce this.
// Throughput: one transaction per cycle while result is not stalled. A
// transaction passes through 50 register stages from acceptance to result
// valid: 6 temperature, 6 polynomial, 32 divider (two quotient bits each)
// and 6 correction stages, the last of which is the output register.
// The whole pipeline advances together; when result is stalled every stage
// holds and sample.ready drops, so nothing is lost or repeated. A slot frees
// as soon as the output register is taken.
// Reset clears all calibration registers and all stage valid bits.
module baro_sensor_compensation_core (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [1:0]   cfg_index,
	input  logic [63:0]  cfg_wdata,
	bsc_stream_if.sink   sample,
	bsc_stream_if.source result
);

	logic [47:0] temp_cal_q;
	logic [63:0] press_cal_a_q;
	logic [63:0] press_cal_b_q;
	logic [15:0] press_cal_c_q;

	bsc_pkg::cal_t    cal;
	logic             adv;
	logic             t_valid, p_valid, d_valid;
	bsc_pkg::tag_t    t_tag, p_tag, d_tag;
	logic signed [32:0] t_v1;
	logic [19:0]      t_adc_p;
	logic [63:0]      p_num;
	logic [30:0]      p_den;
	logic             p_qneg;
	logic [63:0]      d_quot;
	logic             d_qneg;
	logic             out_valid;
	bsc_pkg::result_t out_data;

	// calibration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_cal_q    <= '0;
			press_cal_a_q <= '0;
			press_cal_b_q <= '0;
			press_cal_c_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				bsc_pkg::RegTempCal:   temp_cal_q    <= cfg_wdata[47:0];
				bsc_pkg::RegPressCalA: press_cal_a_q <= cfg_wdata;
				bsc_pkg::RegPressCalB: press_cal_b_q <= cfg_wdata;
				bsc_pkg::RegPressCalC: press_cal_c_q <= cfg_wdata[15:0];
			endcase
		end
	end

	// coefficient split
	always_comb begin
		cal.t1 = temp_cal_q[15:0];
		cal.t2 = temp_cal_q[31:16];
		cal.t3 = temp_cal_q[47:32];
		cal.p1 = press_cal_a_q[15:0];
		cal.p2 = press_cal_a_q[31:16];
		cal.p3 = press_cal_a_q[47:32];
		cal.p4 = press_cal_a_q[63:48];
		cal.p5 = press_cal_b_q[15:0];
		cal.p6 = press_cal_b_q[31:16];
		cal.p7 = press_cal_b_q[47:32];
		cal.p8 = press_cal_b_q[63:48];
		cal.p9 = press_cal_c_q;
	end

	// global advance: output register empty or being taken
	assign adv          = !out_valid || result.ready;
	assign sample.ready = adv;

	bsc_temp u_temp (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (sample.valid),
		.in_data   (sample.data),
		.cal       (cal),
		.out_valid (t_valid),
		.out_tag   (t_tag),
		.out_v1    (t_v1),
		.out_adc_p (t_adc_p)
	);

	bsc_poly u_poly (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (t_valid),
		.in_tag    (t_tag),
		.in_v1     (t_v1),
		.in_adc_p  (t_adc_p),
		.cal       (cal),
		.out_valid (p_valid),
		.out_tag   (p_tag),
		.out_num   (p_num),
		.out_den   (p_den),
		.out_qneg  (p_qneg)
	);

	bsc_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (p_valid),
		.in_tag    (p_tag),
		.in_num    (p_num),
		.in_den    (p_den),
		.in_qneg   (p_qneg),
		.out_valid (d_valid),
		.out_tag   (d_tag),
		.out_quot  (d_quot),
		.out_qneg  (d_qneg)
	);

	bsc_post u_post (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (d_valid),
		.in_tag    (d_tag),
		.in_quot   (d_quot),
		.in_qneg   (d_qneg),
		.cal       (cal),
		.out_valid (out_valid),
		.out_data  (out_data)
	);

	assign result.valid = out_valid;
	assign result.data  = out_data;

	// status code 3 is never produced
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.status != 2'd3))
		else $error("reserved status code on result");

	// a not-ready result carries zero fields
	a_not_ready_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.status == bsc_pkg::StatusNotReady) |->
		(out_data.temperature_centi == 32'sd0 && out_data.pressure_q24_8 == 32'd0))
		else $error("not-ready result with nonzero fields");

	// a good result never has zero pressure
	a_ok_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.status == bsc_pkg::StatusOk) |->
		(out_data.pressure_q24_8 != 32'd0))
		else $error("ok status with zero pressure");

endmodule
